// ===== design/pph_pkg.sv =====
// Shared types and constants for the polygon pick hit test.
package pph_pkg;

    // Default coordinate width (signed Q12.4).
    localparam int COORD_WIDTH_DEF = 16;

    // Configuration register indexes.
    localparam int CFG_INDEX_WIDTH = 3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RECT_MODE   = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PICK_X      = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PICK_Y      = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RECT_HIGH_X = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RECT_HIGH_Y = 3'd4;

    // Vertex counter saturates at three; fewer than two earlier vertices
    // on the final word means the polygon is degenerate.
    localparam int COUNT_WIDTH = 2;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX        = 2'd3;
    localparam logic [COUNT_WIDTH-1:0] MIN_HIT_VERTICES = 2'd2;

    // Per-word control flags travelling down the pipe.
    typedef struct packed {
        logic last;      // final vertex of the polygon
        logic do_edge;   // edge from previous vertex is tested
        logic do_close;  // closing edge back to first vertex is tested
        logic degen;     // fewer than three vertices in the polygon
    } pph_flags_t;

    // Stage load enables for the edge sign units.
    typedef struct packed {
        logic load_b;
        logic load_c;
    } pph_adv_t;

endpackage

// ===== design/pph_edge_sign.sv =====
// Pipelined edge side test: sign of the cross product of an edge and the pick point.
module pph_edge_sign #(
    parameter int COORD_WIDTH = pph_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  pph_pkg::pph_adv_t             adv,
    input  logic signed [COORD_WIDTH-1:0] pick_x,
    input  logic signed [COORD_WIDTH-1:0] pick_y,
    input  logic signed [COORD_WIDTH-1:0] from_x,
    input  logic signed [COORD_WIDTH-1:0] from_y,
    input  logic signed [COORD_WIDTH-1:0] to_x,
    input  logic signed [COORD_WIDTH-1:0] to_y,
    output logic                          pos,
    output logic                          neg
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] dyf_reg, dxe_reg, dxf_reg, dye_reg;
    logic signed [DW-1:0] dyf_next, dxe_next, dxf_next, dye_next;
    logic signed [PW-1:0] p1_reg, p2_reg;
    logic signed [PW-1:0] p1_next, p2_next;

    // stage B: exact differences, one bit wider
    assign dyf_next = {pick_y[COORD_WIDTH-1], pick_y} - {from_y[COORD_WIDTH-1], from_y};
    assign dxe_next = {to_x[COORD_WIDTH-1], to_x}     - {from_x[COORD_WIDTH-1], from_x};
    assign dxf_next = {pick_x[COORD_WIDTH-1], pick_x} - {from_x[COORD_WIDTH-1], from_x};
    assign dye_next = {to_y[COORD_WIDTH-1], to_y}     - {from_y[COORD_WIDTH-1], from_y};

    // stage C: two independent full-width products
    assign p1_next = dyf_reg * dxe_reg;
    assign p2_next = dxf_reg * dye_reg;

    always_ff @(posedge clk)
    begin
        if (adv.load_b)
        begin
            dyf_reg <= dyf_next;
            dxe_reg <= dxe_next;
            dxf_reg <= dxf_next;
            dye_reg <= dye_next;
        end
        if (adv.load_c)
        begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
    end

    // sign of p1 - p2, exact
    assign pos = p1_reg > p2_reg;
    assign neg = p1_reg < p2_reg;

endmodule

// ===== design/pph_vertex_track.sv =====
// Vertex tracking: first and previous vertex, count, and the input stage register.
module pph_vertex_track #(
    parameter int COORD_WIDTH = pph_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic                          load_a,
    input  logic signed [COORD_WIDTH-1:0] vertex_x,
    input  logic signed [COORD_WIDTH-1:0] vertex_y,
    input  logic                          last_vertex,
    output logic                          a_valid,
    output logic signed [COORD_WIDTH-1:0] cur_x,
    output logic signed [COORD_WIDTH-1:0] cur_y,
    output logic signed [COORD_WIDTH-1:0] prev_x,
    output logic signed [COORD_WIDTH-1:0] prev_y,
    output logic signed [COORD_WIDTH-1:0] first_x,
    output logic signed [COORD_WIDTH-1:0] first_y,
    output pph_pkg::pph_flags_t           flags
);

    logic [pph_pkg::COUNT_WIDTH-1:0] count_reg, count_next;
    logic signed [COORD_WIDTH-1:0]   first_x_reg, first_y_reg;
    logic signed [COORD_WIDTH-1:0]   prev_x_reg, prev_y_reg;
    logic signed [COORD_WIDTH-1:0]   a_cur_x_reg, a_cur_y_reg;
    logic signed [COORD_WIDTH-1:0]   a_prev_x_reg, a_prev_y_reg;
    logic signed [COORD_WIDTH-1:0]   a_first_x_reg, a_first_y_reg;
    pph_pkg::pph_flags_t             a_flags_reg, a_flags_next;
    logic                            a_valid_reg;
    logic                            first_word;

    assign first_word = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (last_vertex)
            count_next = '0;
        else if (count_reg < pph_pkg::COUNT_MAX)
            count_next = count_reg + 1'b1;
    end

    always_comb
    begin
        a_flags_next.last     = last_vertex;
        a_flags_next.do_edge  = !first_word;
        a_flags_next.do_close = last_vertex && !first_word;
        a_flags_next.degen    = count_reg < pph_pkg::MIN_HIT_VERTICES;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                count_reg <= count_next;
            if (load_a)
                a_valid_reg <= take;
        end
    end

    // payload: no reset, written before use
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (first_word)
            begin
                first_x_reg <= vertex_x;
                first_y_reg <= vertex_y;
            end
            prev_x_reg    <= vertex_x;
            prev_y_reg    <= vertex_y;
            a_cur_x_reg   <= vertex_x;
            a_cur_y_reg   <= vertex_y;
            a_prev_x_reg  <= prev_x_reg;
            a_prev_y_reg  <= prev_y_reg;
            a_first_x_reg <= first_word ? vertex_x : first_x_reg;
            a_first_y_reg <= first_word ? vertex_y : first_y_reg;
            a_flags_reg   <= a_flags_next;
        end
    end

    assign a_valid = a_valid_reg;
    assign cur_x   = a_cur_x_reg;
    assign cur_y   = a_cur_y_reg;
    assign prev_x  = a_prev_x_reg;
    assign prev_y  = a_prev_y_reg;
    assign first_x = a_first_x_reg;
    assign first_y = a_first_y_reg;
    assign flags   = a_flags_reg;

endmodule

// ===== design/polygon_pick_hit_test.sv =====
// Top level of the polygon pick hit test.
//
// Vertex words of one polygon stream in on the input channel, in order, with
// last_vertex set on the final one; one result word (hit, degenerate) comes out
// per polygon, nothing for the other vertices. The block takes one vertex word
// every clock cycle while in_stall is low. Each word passes an input stage, a
// difference stage and a product stage, then the result word is registered for
// the output channel; the two multipliers of each edge unit occupy one pipeline
// slot per word, which sets the rate at one word a cycle when nothing stalls. A
// result held in the output register does not block the pipe until a second
// result reaches the product stage while the first is still stalled. Point
// mode (rect_mode = 0) hits when the pick point is strictly on the same side
// of every edge, closing edge included; convex polygons only. Rectangle mode
// hits when every vertex lies in the inclusive rectangle from (pick_x, pick_y)
// to (rect_high_x, rect_high_y). Write the registers only while the block is
// idle; rect_mode is sampled when the final vertex leaves the product stage.
module polygon_pick_hit_test #(
    parameter int COORD_WIDTH = pph_pkg::COORD_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_write,
    input  logic [pph_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [COORD_WIDTH-1:0]              cfg_data,
    // vertex input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [COORD_WIDTH-1:0]       vertex_x,
    input  logic signed [COORD_WIDTH-1:0]       vertex_y,
    input  logic                                last_vertex,
    // result output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                hit,
    output logic                                degenerate
);

    // configuration registers
    logic                          rect_mode_reg;
    logic signed [COORD_WIDTH-1:0] pick_x_reg, pick_y_reg;
    logic signed [COORD_WIDTH-1:0] rect_high_x_reg, rect_high_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_mode_reg   <= 1'b0;
            pick_x_reg      <= '0;
            pick_y_reg      <= '0;
            rect_high_x_reg <= '0;
            rect_high_y_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                pph_pkg::REG_RECT_MODE:   rect_mode_reg   <= cfg_data[0];
                pph_pkg::REG_PICK_X:      pick_x_reg      <= cfg_data;
                pph_pkg::REG_PICK_Y:      pick_y_reg      <= cfg_data;
                pph_pkg::REG_RECT_HIGH_X: rect_high_x_reg <= cfg_data;
                pph_pkg::REG_RECT_HIGH_Y: rect_high_y_reg <= cfg_data;
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    // pipeline flow control: a stage moves when the next one is free or moving
    logic                b_valid_reg, c_valid_reg, out_valid_reg;
    pph_pkg::pph_flags_t b_flags_reg, c_flags_reg;
    logic                b_in_rect_reg, c_in_rect_reg;
    logic                a_valid;
    logic                out_free, ready_a, ready_b, ready_c;
    logic                take, consume_c;
    pph_pkg::pph_adv_t   adv;

    assign out_free  = !out_valid_reg || !out_stall;
    assign ready_c   = !c_valid_reg || !c_flags_reg.last || out_free;
    assign ready_b   = !b_valid_reg || ready_c;
    assign ready_a   = !a_valid || ready_b;
    assign in_stall  = !ready_a;
    assign take      = in_valid && ready_a;
    assign consume_c = c_valid_reg && ready_c;

    assign adv.load_b = ready_b;
    assign adv.load_c = ready_c;

    // stage A: input word plus edge endpoints
    logic signed [COORD_WIDTH-1:0] cur_x, cur_y, prev_x, prev_y, first_x, first_y;
    pph_pkg::pph_flags_t           a_flags;

    pph_vertex_track #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .load_a      (ready_a),
        .vertex_x    (vertex_x),
        .vertex_y    (vertex_y),
        .last_vertex (last_vertex),
        .a_valid     (a_valid),
        .cur_x       (cur_x),
        .cur_y       (cur_y),
        .prev_x      (prev_x),
        .prev_y      (prev_y),
        .first_x     (first_x),
        .first_y     (first_y),
        .flags       (a_flags)
    );

    // edge from previous vertex to this one
    logic edge_pos, edge_neg;

    pph_edge_sign #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_edge (
        .clk    (clk),
        .adv    (adv),
        .pick_x (pick_x_reg),
        .pick_y (pick_y_reg),
        .from_x (prev_x),
        .from_y (prev_y),
        .to_x   (cur_x),
        .to_y   (cur_y),
        .pos    (edge_pos),
        .neg    (edge_neg)
    );

    // closing edge from this vertex back to the first
    logic close_pos, close_neg;

    pph_edge_sign #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_close (
        .clk    (clk),
        .adv    (adv),
        .pick_x (pick_x_reg),
        .pick_y (pick_y_reg),
        .from_x (cur_x),
        .from_y (cur_y),
        .to_x   (first_x),
        .to_y   (first_y),
        .pos    (close_pos),
        .neg    (close_neg)
    );

    // inclusive rectangle test, done on the way into stage B
    logic in_rect_next;

    assign in_rect_next = (cur_x >= pick_x_reg) && (cur_y >= pick_y_reg) &&
                          (cur_x <= rect_high_x_reg) && (cur_y <= rect_high_y_reg);

    // polygon accumulators, updated as words leave stage C
    logic all_left_reg, all_right_reg, all_in_rect_reg;
    logic left_next, right_next, in_rect_acc;
    logic hit_reg, degenerate_reg, hit_next;

    always_comb
    begin
        left_next   = all_left_reg &&
                      (!c_flags_reg.do_edge || edge_pos) &&
                      (!c_flags_reg.do_close || close_pos);
        right_next  = all_right_reg &&
                      (!c_flags_reg.do_edge || edge_neg) &&
                      (!c_flags_reg.do_close || close_neg);
        in_rect_acc = all_in_rect_reg && c_in_rect_reg;
        if (rect_mode_reg)
            hit_next = in_rect_acc;
        else
            hit_next = !c_flags_reg.degen && (left_next || right_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg     <= 1'b0;
            c_valid_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            all_left_reg    <= 1'b1;
            all_right_reg   <= 1'b1;
            all_in_rect_reg <= 1'b1;
        end
        else
        begin
            if (ready_b)
                b_valid_reg <= a_valid;
            if (ready_c)
                c_valid_reg <= b_valid_reg;
            if (out_free)
                out_valid_reg <= consume_c && c_flags_reg.last;
            if (consume_c)
            begin
                if (c_flags_reg.last)
                begin
                    all_left_reg    <= 1'b1;
                    all_right_reg   <= 1'b1;
                    all_in_rect_reg <= 1'b1;
                end
                else
                begin
                    all_left_reg    <= left_next;
                    all_right_reg   <= right_next;
                    all_in_rect_reg <= in_rect_acc;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ready_b)
        begin
            b_flags_reg   <= a_flags;
            b_in_rect_reg <= in_rect_next;
        end
        if (ready_c)
        begin
            c_flags_reg   <= b_flags_reg;
            c_in_rect_reg <= b_in_rect_reg;
        end
        if (consume_c && c_flags_reg.last)
        begin
            hit_reg        <= hit_next;
            degenerate_reg <= c_flags_reg.degen;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign degenerate = degenerate_reg;

endmodule
